### sv/rv32_pkg.sv
package rv32_pkg;

    localparam int MEM_BYTES_DEFAULT = 65536;

    // commands
    localparam logic [1:0] CMD_STEP  = 2'd0;
    localparam logic [1:0] CMD_WRMEM = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;
    localparam logic [1:0] CMD_SETPC = 2'd3;

    // status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BREAK     = 3'd1;
    localparam logic [2:0] ST_UNKNOWN   = 3'd2;
    localparam logic [2:0] ST_MISALIGN  = 3'd3;
    localparam logic [2:0] ST_BAD_WIDTH = 3'd4;
    localparam logic [2:0] ST_HELD      = 3'd5;

    // opcodes
    localparam logic [6:0] OP_OP     = 7'b0110011;
    localparam logic [6:0] OP_IMM    = 7'b0010011;
    localparam logic [6:0] OP_LOAD   = 7'b0000011;
    localparam logic [6:0] OP_STORE  = 7'b0100011;
    localparam logic [6:0] OP_BRANCH = 7'b1100011;
    localparam logic [6:0] OP_JAL    = 7'b1101111;
    localparam logic [6:0] OP_JALR   = 7'b1100111;
    localparam logic [6:0] OP_LUI    = 7'b0110111;
    localparam logic [6:0] OP_AUIPC  = 7'b0010111;
    localparam logic [6:0] OP_SYSTEM = 7'b1110011;

    localparam logic [31:0] U_MASK = 32'hFFFFF000;

    // one 8-bit lane request to the byte memory bank
    typedef struct packed {
        logic        we;
        logic [31:0] addr;
        logic [7:0]  wdata;
    } lane_req_t;

    function automatic logic [31:0] alu(input logic [2:0] f3, input logic [31:0] a,
                                        input logic [31:0] b, input logic alt);
        logic [4:0] sh;
        logic [31:0] r;
        sh = b[4:0];
        case (f3)
            3'd0: r = alt ? a - b : a + b;
            3'd1: r = a << sh;
            3'd2: r = {31'd0, $signed(a) < $signed(b)};
            3'd3: r = {31'd0, a < b};
            3'd4: r = a ^ b;
            3'd5: r = alt ? 32'($signed(a) >>> sh) : a >> sh;
            3'd6: r = a | b;
            default: r = a & b;
        endcase
        return r;
    endfunction

endpackage

### sv/rv32i_instruction_core.sv
// RV32I core stepped by request. A step runs from accept through fetch (the
// instruction word is read from the byte memory), register read and execute
// (a load adds one more memory read in its own load state), then the result
// is registered. Memory writes, clear, set pc and held steps go from fetch
// straight to the result. The registered memory read on each of the fetch,
// register and load accesses sets this sequence. One request is in flight at a
// time, and the next request is taken in the cycle after the result leaves; a
// stalled result stalls the input for as long. MEM_BYTES must be a power of two.
module rv32i_instruction_core #(
    parameter int MEM_BYTES = rv32_pkg::MEM_BYTES_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,           // run_enable
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,            // cmd, mem_address, mem_byte, new_pc, pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata             // pc_after, reg_written, reg_index,
                                            // reg_value, status, pad
);
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_FETCH = 6'b000010,
        S_REG   = 6'b000100,
        S_EXEC  = 6'b001000,
        S_LOAD  = 6'b010000,
        S_OUT   = 6'b100000
    } state_t;

    state_t      state_reg, state_next;
    logic        run_reg;
    logic [31:0] pc_reg;
    logic [1:0]  cmd_reg;
    logic [15:0] newpc_reg;
    logic [31:0] ins_reg, ld_addr_reg;
    logic [2:0]  ld_f3_reg;
    logic [4:0]  ld_rd_reg;

    logic [31:0] out_pc_reg, out_val_reg;
    logic        out_wr_reg;
    logic [4:0]  out_rd_reg;
    logic [2:0]  out_st_reg;

    rv32_pkg::lane_req_t lane [4];
    logic [31:0] mem_q, ra_q, rb_q;
    logic        rf_we, rf_clear;
    logic [4:0]  rf_wa;
    logic [31:0] rf_wd;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = (state_reg == S_OUT);
    assign m_tdata   = {7'd0, out_st_reg, out_val_reg, out_rd_reg, out_wr_reg, out_pc_reg};

    rv32_bytemem #(.MEM_BYTES(MEM_BYTES)) u_mem (.clk(clk), .req(lane), .rdata(mem_q));

    // register read addresses come straight from the fetched word in S_REG
    rv32_regfile u_rf (
        .clk(clk), .rst_n(rst_n), .clear(rf_clear),
        .ra(mem_q[19:15]), .rb(mem_q[24:20]), .qa(ra_q), .qb(rb_q),
        .we(rf_we), .wa(rf_wa), .wd(rf_wd)
    );

    // decode fields
    logic [6:0]  op;
    logic [2:0]  f3;
    logic [4:0]  rd;
    logic [31:0] imm_i, imm_s, imm_b, imm_j, imm_u, pc4, d_addr;
    assign op    = ins_reg[6:0];
    assign f3    = ins_reg[14:12];
    assign rd    = ins_reg[11:7];
    assign imm_i = {{20{ins_reg[31]}}, ins_reg[31:20]};
    assign imm_s = {{20{ins_reg[31]}}, ins_reg[31:25], ins_reg[11:7]};
    assign imm_b = {{19{ins_reg[31]}}, ins_reg[31], ins_reg[7], ins_reg[30:25],
                    ins_reg[11:8], 1'b0};
    assign imm_j = {{11{ins_reg[31]}}, ins_reg[31], ins_reg[19:12], ins_reg[20],
                    ins_reg[30:21], 1'b0};
    assign imm_u = ins_reg & rv32_pkg::U_MASK;
    assign pc4   = pc_reg + 32'd4;
    assign d_addr = ra_q + ((op == rv32_pkg::OP_STORE) ? imm_s : imm_i);

    // execute results
    logic [31:0] x_val, x_next;
    logic        x_wr, x_take, x_load, x_mis;
    logic [2:0]  x_st;
    always_comb
    begin
        x_val  = 32'd0;
        x_wr   = 1'b0;
        x_next = pc4;
        x_st   = rv32_pkg::ST_OK;
        x_take = 1'b0;
        x_load = 1'b0;
        x_mis  = ((f3[1:0] == 2'd1) && d_addr[0]) ||
                 ((f3[1:0] == 2'd2) && (d_addr[1:0] != 2'd0));
        case (op)
            rv32_pkg::OP_OP:
            begin
                x_val = rv32_pkg::alu(f3, ra_q, rb_q,
                                      ins_reg[30] && (f3 == 3'd0 || f3 == 3'd5));
                x_wr  = 1'b1;
            end
            rv32_pkg::OP_IMM:
            begin
                x_val = rv32_pkg::alu(f3, ra_q, imm_i, ins_reg[30] && f3 == 3'd5);
                x_wr  = 1'b1;
            end
            rv32_pkg::OP_LOAD:
            begin
                if (f3 == 3'd3 || f3 == 3'd6 || f3 == 3'd7)
                    x_st = rv32_pkg::ST_BAD_WIDTH;
                else
                begin
                    x_load = 1'b1;
                    if (x_mis)
                        x_st = rv32_pkg::ST_MISALIGN;
                end
            end
            rv32_pkg::OP_STORE:
            begin
                if (f3 > 3'd2)
                    x_st = rv32_pkg::ST_BAD_WIDTH;
                else if (x_mis)
                    x_st = rv32_pkg::ST_MISALIGN;
            end
            rv32_pkg::OP_BRANCH:
            begin
                case (f3)
                    3'd0: x_take = ra_q == rb_q;
                    3'd1: x_take = ra_q != rb_q;
                    3'd4: x_take = $signed(ra_q) < $signed(rb_q);
                    3'd5: x_take = $signed(ra_q) >= $signed(rb_q);
                    3'd6: x_take = ra_q < rb_q;
                    3'd7: x_take = ra_q >= rb_q;
                    default: x_st = rv32_pkg::ST_UNKNOWN;
                endcase
                if (x_take)
                    x_next = (pc_reg + imm_b) & 32'hFFFFFFFC;
            end
            rv32_pkg::OP_JAL:
            begin
                x_val  = pc4;
                x_wr   = 1'b1;
                x_next = (pc_reg + imm_j) & 32'hFFFFFFFC;
            end
            rv32_pkg::OP_JALR:
            begin
                x_val  = pc4;
                x_wr   = 1'b1;
                x_next = (ra_q + imm_i) & 32'hFFFFFFFC;
            end
            rv32_pkg::OP_LUI:
            begin
                x_val = imm_u;
                x_wr  = 1'b1;
            end
            rv32_pkg::OP_AUIPC:
            begin
                x_val = pc_reg + imm_u;
                x_wr  = 1'b1;
            end
            rv32_pkg::OP_SYSTEM: x_st = rv32_pkg::ST_BREAK;
            default: x_st = rv32_pkg::ST_UNKNOWN;
        endcase
    end

    // load data formatting
    logic [31:0] ld_val;
    always_comb
    begin
        case (ld_f3_reg)
            3'd0: ld_val = {{24{mem_q[7]}}, mem_q[7:0]};
            3'd1: ld_val = {{16{mem_q[15]}}, mem_q[15:0]};
            3'd4: ld_val = {24'd0, mem_q[7:0]};
            3'd5: ld_val = {16'd0, mem_q[15:0]};
            default: ld_val = mem_q;
        endcase
    end

    // memory lanes: fetch, load, store or byte write
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            lane[i].we    = 1'b0;
            lane[i].addr  = pc_reg + 32'(i);
            lane[i].wdata = rb_q[8*i +: 8];
            if (state_reg == S_EXEC)
            begin
                lane[i].addr = d_addr + 32'(i);
                lane[i].we   = (op == rv32_pkg::OP_STORE) && (f3 <= 3'd2) &&
                               (i < (1 << f3[1:0]));
            end
            else if (state_reg == S_IDLE)
            begin
                lane[i].addr  = {16'd0, s_tdata[17:2]} + 32'(i);
                lane[i].wdata = s_tdata[25:18];
                lane[i].we    = (i == 0) && s_tvalid &&
                                (s_tdata[1:0] == rv32_pkg::CMD_WRMEM);
            end
        end
    end

    // register file write and clear
    always_comb
    begin
        rf_clear = (state_reg == S_FETCH) && (cmd_reg == rv32_pkg::CMD_CLEAR);
        rf_we    = 1'b0;
        rf_wa    = rd;
        rf_wd    = x_val;
        if (state_reg == S_EXEC)
            rf_we = x_wr && (rd != 5'd0);
        else if (state_reg == S_LOAD)
        begin
            rf_we = (ld_rd_reg != 5'd0);
            rf_wa = ld_rd_reg;
            rf_wd = ld_val;
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (s_tvalid) state_next = S_FETCH;
            S_FETCH: state_next = (cmd_reg == rv32_pkg::CMD_STEP && run_reg) ? S_REG : S_OUT;
            S_REG:   state_next = S_EXEC;
            S_EXEC:  state_next = x_load ? S_LOAD : S_OUT;
            S_LOAD:  state_next = S_OUT;
            S_OUT:   if (m_tready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            run_reg   <= 1'b1;
            pc_reg    <= 32'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                run_reg <= cfg_data;
            if (state_reg == S_FETCH && cmd_reg == rv32_pkg::CMD_CLEAR)
                pc_reg <= 32'd0;
            else if (state_reg == S_FETCH && cmd_reg == rv32_pkg::CMD_SETPC)
                pc_reg <= {16'd0, newpc_reg[15:2], 2'b00};
            else if (state_reg == S_EXEC)
                pc_reg <= x_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && s_tvalid)
        begin
            cmd_reg     <= s_tdata[1:0];
            newpc_reg   <= s_tdata[41:26];
        end
        if (state_reg == S_REG)
            ins_reg <= mem_q;
        case (state_reg)
            S_FETCH:
            begin
                out_wr_reg  <= 1'b0;
                out_rd_reg  <= 5'd0;
                out_val_reg <= 32'd0;
                out_st_reg  <= (cmd_reg == rv32_pkg::CMD_STEP) ? rv32_pkg::ST_HELD
                                                               : rv32_pkg::ST_OK;
                case (cmd_reg)
                    rv32_pkg::CMD_CLEAR: out_pc_reg <= 32'd0;
                    rv32_pkg::CMD_SETPC: out_pc_reg <= {16'd0, newpc_reg[15:2], 2'b00};
                    default:             out_pc_reg <= pc_reg;
                endcase
            end
            S_EXEC:
            begin
                out_pc_reg  <= x_next;
                out_st_reg  <= x_st;
                out_wr_reg  <= x_wr && (rd != 5'd0);
                out_rd_reg  <= (x_wr && rd != 5'd0) ? rd : 5'd0;
                out_val_reg <= (x_wr && rd != 5'd0) ? x_val : 32'd0;
                ld_f3_reg   <= f3;
                ld_rd_reg   <= rd;
                ld_addr_reg <= d_addr;
            end
            S_LOAD:
            begin
                out_wr_reg  <= (ld_rd_reg != 5'd0);
                out_rd_reg  <= ld_rd_reg;
                out_val_reg <= (ld_rd_reg != 5'd0) ? ld_val : 32'd0;
            end
            default: ;
        endcase
    end

    // assertions
    a_x0_never: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(out_wr_reg && out_rd_reg == 5'd0))
        else $error("result reports a write to x0");
    a_held: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_st_reg == rv32_pkg::ST_HELD) |-> !out_wr_reg)
        else $error("held step wrote a register");
    a_pc_align: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (out_pc_reg[1:0] == pc_reg[1:0]) && (out_pc_reg == pc_reg))
        else $error("reported pc differs from pc");
    a_in_out: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !m_tvalid)
        else $error("accepting while result pending");
    a_ld_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOAD) |-> $past(state_reg == S_EXEC) && ld_addr_reg == $past(d_addr))
        else $error("load sequencing broken");
endmodule

### sv/rv32_bytemem.sv
// Four byte-wide banks interleaved on the low two address bits; lane i serves
// byte address addr+i. Four consecutive addresses always land in four different
// banks, so each bank sees one read and at most one write per cycle.
// MEM_BYTES must be a power of two; addresses wrap by dropping the upper bits.
module rv32_bytemem #(
    parameter int MEM_BYTES = rv32_pkg::MEM_BYTES_DEFAULT
) (
    input  logic                 clk,
    input  rv32_pkg::lane_req_t  req [4],
    output logic [31:0]          rdata
);
    localparam int AW   = $clog2(MEM_BYTES);
    localparam int ROWS = MEM_BYTES / 4;

    logic [AW-3:0] bank_row [4];
    logic [7:0]    bank_wdata [4];
    logic [3:0]    bank_we;
    logic [31:0]   bank_q;
    logic [1:0]    lane_bank_reg [4];

    // steer each lane to the bank its address selects
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            bank_row[k]   = '0;
            bank_wdata[k] = '0;
            bank_we[k]    = 1'b0;
            for (int i = 0; i < 4; i++)
            begin
                if (req[i].addr[1:0] == 2'(k))
                begin
                    bank_row[k]   = req[i].addr[AW-1:2];
                    bank_wdata[k] = req[i].wdata;
                    bank_we[k]    = req[i].we;
                end
            end
        end
    end

    // one write and one registered read per bank
    for (genvar k = 0; k < 4; k++)
    begin : g_bank
        logic [7:0] mem [ROWS];
        logic [7:0] q_reg;

        always_ff @(posedge clk)
        begin
            if (bank_we[k])
                mem[bank_row[k]] <= bank_wdata[k];
            q_reg <= mem[bank_row[k]];
        end

        assign bank_q[8*k +: 8] = q_reg;
    end

    // bank each lane read, to rotate the data back into lane order
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
            lane_bank_reg[i] <= req[i].addr[1:0];
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
            rdata[8*i +: 8] = bank_q[8*lane_bank_reg[i] +: 8];
    end
endmodule

### sv/rv32_regfile.sv
// Register file: 32x32 synchronous memory, two registered reads, one write.
// Valid bits stand in for the reset and clear values of zero.
module rv32_regfile (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        clear,
    input  logic [4:0]  ra,
    input  logic [4:0]  rb,
    output logic [31:0] qa,
    output logic [31:0] qb,
    input  logic        we,
    input  logic [4:0]  wa,
    input  logic [31:0] wd
);
    logic [31:0] mem [32];
    logic [31:0] valid_reg;
    logic [31:0] qa_raw_reg, qb_raw_reg;
    logic        va_reg, vb_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[wa] <= wd;
        qa_raw_reg <= mem[ra];
        qb_raw_reg <= mem[rb];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            va_reg    <= 1'b0;
            vb_reg    <= 1'b0;
        end
        else
        begin
            va_reg <= valid_reg[ra] && (ra != 5'd0);
            vb_reg <= valid_reg[rb] && (rb != 5'd0);
            if (clear)
                valid_reg <= '0;
            else if (we)
                valid_reg[wa] <= 1'b1;
        end
    end

    assign qa = va_reg ? qa_raw_reg : 32'd0;
    assign qb = vb_reg ? qb_raw_reg : 32'd0;
endmodule

### sim/tb_rv32i_instruction_core.sv
module tb_rv32i_instruction_core;

    localparam int CYCLE_LIMIT = 800000;
    localparam int RANDOM_REQS = 1300;

    typedef struct packed {
        logic [31:0] pc_after;
        logic        reg_written;
        logic [4:0]  reg_index;
        logic [31:0] reg_value;
        logic [2:0]  status;
    } core_result_t;

    // one row of the directed table; word is the instruction for step rows
    typedef struct {
        logic [1:0]  cmd;
        logic [15:0] addr;
        logic [7:0]  data;
        logic [15:0] pc;
        logic [31:0] word;
        bit          typed;
        logic [31:0] exp_pc;
        logic [2:0]  exp_status;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;       // cmd, mem_address, mem_byte, new_pc, pad
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;       // pc_after, reg_written, reg_index, reg_value, status, pad

    // shadow state of the core
    logic [31:0] gpr [32];
    logic [31:0] cur_pc;
    logic [7:0]  ram [65536];
    bit          ram_valid [65536];
    logic        run_en;

    core_result_t pending_results[$];
    int errors;
    int cycles;
    int issued;
    bit quiet_tx;
    bit quiet_rx;

    rv32i_instruction_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL rv32i_instruction_core");
            $finish;
        end
    end

    function automatic logic [31:0] ram_word(input logic [31:0] a, input int n);
        logic [31:0] v;
        v = 32'd0;
        for (int i = 0; i < n; i++)
            v |= 32'(ram[16'(a + 32'(i))]) << (8 * i);
        return v;
    endfunction

    function automatic logic [31:0] alu_calc(input logic [2:0] f3, input logic [31:0] a,
                                             input logic [31:0] b, input logic alt);
        logic [4:0] sh;
        sh = b[4:0];
        case (f3)
            3'd0: return alt ? a - b : a + b;
            3'd1: return a << sh;
            3'd2: return {31'd0, (a ^ 32'h8000_0000) < (b ^ 32'h8000_0000)};
            3'd3: return {31'd0, a < b};
            3'd4: return a ^ b;
            3'd5: return alt ? 32'($signed(a) >>> sh) : a >> sh;
            3'd6: return a | b;
            default: return a & b;
        endcase
    endfunction

    // load width in bytes, 0 when funct3 has no meaning
    function automatic int load_bytes(input logic [2:0] f3);
        case (f3)
            3'd0, 3'd4: return 1;
            3'd1, 3'd5: return 2;
            3'd2: return 4;
            default: return 0;
        endcase
    endfunction

    // advance the shadow core by one request and return its result
    function automatic core_result_t core_predict(input logic [1:0] cmd,
            input logic [15:0] addr, input logic [7:0] data, input logic [15:0] npc);
        core_result_t r;
        logic [31:0] ins, a, b, imm_i, imm_s, imm_b, imm_j, ea, val, pc_next;
        logic [2:0]  f3;
        logic [4:0]  rd;
        logic        wr, take;
        int          n;
        r = '0;
        wr = 1'b0;
        val = 32'd0;
        rd = 5'd0;
        if (cmd == rv32_pkg::CMD_WRMEM)
        begin
            ram[addr] = data;
            ram_valid[addr] = 1'b1;
        end
        else if (cmd == rv32_pkg::CMD_CLEAR)
        begin
            foreach (gpr[i]) gpr[i] = 32'd0;
            cur_pc = 32'd0;
        end
        else if (cmd == rv32_pkg::CMD_SETPC)
            cur_pc = {16'd0, npc[15:2], 2'b00};
        else if (!run_en)
            r.status = rv32_pkg::ST_HELD;
        else
        begin
            ins = ram_word(cur_pc, 4);
            f3 = ins[14:12];
            rd = ins[11:7];
            a = gpr[ins[19:15]];
            b = gpr[ins[24:20]];
            imm_i = {{20{ins[31]}}, ins[31:20]};
            imm_s = {{20{ins[31]}}, ins[31:25], ins[11:7]};
            imm_b = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
            imm_j = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
            pc_next = cur_pc + 32'd4;
            case (ins[6:0])
                rv32_pkg::OP_OP:
                begin
                    val = alu_calc(f3, a, b, ins[30] && (f3 == 3'd0 || f3 == 3'd5));
                    wr = 1'b1;
                end
                rv32_pkg::OP_IMM:
                begin
                    val = alu_calc(f3, a, imm_i, ins[30] && f3 == 3'd5);
                    wr = 1'b1;
                end
                rv32_pkg::OP_LOAD:
                begin
                    ea = a + imm_i;
                    n = load_bytes(f3);
                    if (n == 0)
                        r.status = rv32_pkg::ST_BAD_WIDTH;
                    else
                    begin
                        val = ram_word(ea, n);
                        if (!f3[2] && n == 1) val = {{24{val[7]}}, val[7:0]};
                        if (!f3[2] && n == 2) val = {{16{val[15]}}, val[15:0]};
                        wr = 1'b1;
                        if ((n == 2 && ea[0]) || (n == 4 && ea[1:0] != 2'b00))
                            r.status = rv32_pkg::ST_MISALIGN;
                    end
                end
                rv32_pkg::OP_STORE:
                begin
                    ea = a + imm_s;
                    if (f3 > 3'd2)
                        r.status = rv32_pkg::ST_BAD_WIDTH;
                    else
                    begin
                        for (int i = 0; i < (1 << f3); i++)
                        begin
                            ram[16'(ea + 32'(i))] = b[8*i +: 8];
                            ram_valid[16'(ea + 32'(i))] = 1'b1;
                        end
                        if ((f3 == 3'd1 && ea[0]) || (f3 == 3'd2 && ea[1:0] != 2'b00))
                            r.status = rv32_pkg::ST_MISALIGN;
                    end
                end
                rv32_pkg::OP_BRANCH:
                begin
                    case (f3)
                        3'd0: take = a == b;
                        3'd1: take = a != b;
                        3'd4: take = $signed(a) < $signed(b);
                        3'd5: take = $signed(a) >= $signed(b);
                        3'd6: take = a < b;
                        3'd7: take = a >= b;
                        default:
                        begin
                            take = 1'b0;
                            r.status = rv32_pkg::ST_UNKNOWN;
                        end
                    endcase
                    if (take)
                        pc_next = (cur_pc + imm_b) & 32'hFFFF_FFFC;
                end
                rv32_pkg::OP_JAL:
                begin
                    val = cur_pc + 32'd4;
                    wr = 1'b1;
                    pc_next = (cur_pc + imm_j) & 32'hFFFF_FFFC;
                end
                rv32_pkg::OP_JALR:
                begin
                    val = cur_pc + 32'd4;
                    wr = 1'b1;
                    pc_next = (a + imm_i) & 32'hFFFF_FFFC;
                end
                rv32_pkg::OP_LUI:
                begin
                    val = ins & rv32_pkg::U_MASK;
                    wr = 1'b1;
                end
                rv32_pkg::OP_AUIPC:
                begin
                    val = cur_pc + (ins & rv32_pkg::U_MASK);
                    wr = 1'b1;
                end
                rv32_pkg::OP_SYSTEM: r.status = rv32_pkg::ST_BREAK;
                default: r.status = rv32_pkg::ST_UNKNOWN;
            endcase
            if (wr && rd != 5'd0)
                gpr[rd] = val;
            else
                wr = 1'b0;
            cur_pc = pc_next;
        end
        r.pc_after = cur_pc;
        r.reg_written = wr;
        r.reg_index = wr ? rd : 5'd0;
        r.reg_value = wr ? val : 32'd0;
        return r;
    endfunction

    // drive one request; valid stays high when the next one follows at once
    task automatic send_req(input logic [1:0] cmd, input logic [15:0] addr,
            input logic [7:0] data, input logic [15:0] npc, input bit typed,
            input core_result_t typed_res);
        core_result_t r;
        int gap;
        gap = quiet_tx ? 0 : $urandom_range(0, 6);
        if (gap > 0 && s_tvalid)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        else if (gap > 0)
            repeat (gap) @(posedge clk);
        r = core_predict(cmd, addr, data, npc);
        pending_results.push_back(typed ? typed_res : r);
        s_tvalid <= 1'b1;
        s_tdata <= {6'd0, npc, data, addr, cmd};
        do @(posedge clk); while (!s_tready);
        issued++;
    endtask

    task automatic send_cmd(input logic [1:0] cmd, input logic [15:0] addr,
            input logic [7:0] data, input logic [15:0] npc);
        send_req(cmd, addr, data, npc, 1'b0, '0);
    endtask

    // step the instruction at pc, writing any load bytes not yet in memory first
    task automatic step_current();
        logic [31:0] ins, ea;
        int n;
        ins = ram_word(cur_pc, 4);
        if (run_en && ins[6:0] == rv32_pkg::OP_LOAD)
        begin
            n = load_bytes(ins[14:12]);
            ea = gpr[ins[19:15]] + {{20{ins[31]}}, ins[31:20]};
            for (int i = 0; i < n; i++)
                if (!ram_valid[16'(ea + 32'(i))])
                    send_cmd(rv32_pkg::CMD_WRMEM, 16'(ea + 32'(i)), 8'($urandom),
                             16'($urandom));
        end
        send_cmd(rv32_pkg::CMD_STEP, 16'($urandom), 8'($urandom), 16'($urandom));
    endtask

    task automatic load_word_at_pc(input logic [31:0] word);
        logic [31:0] base;
        base = cur_pc;
        for (int i = 0; i < 4; i++)
            send_cmd(rv32_pkg::CMD_WRMEM, 16'(base + 32'(i)), word[8*i +: 8],
                     16'($urandom));
    endtask

    // wait for the core to drain before a register write
    task automatic wait_idle();
        if (s_tvalid)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        while (pending_results.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_run_enable(input logic v);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        run_en = v;
    endtask

    function automatic logic [31:0] random_insn();
        logic [31:0] w;
        int k;
        w = $urandom;
        k = $urandom_range(0, 99);
        // mostly standard funct7 on register ops, with the alternate bit random
        if (k < 15)
            w = {1'b0, w[30], 5'd0, w[24:7], rv32_pkg::OP_OP};
        else if (k < 30)
            w = {w[31:7], rv32_pkg::OP_IMM};
        else if (k < 42)
            w = {w[31:7], rv32_pkg::OP_LOAD};
        else if (k < 52)
            w = {w[31:7], rv32_pkg::OP_STORE};
        else if (k < 64)
            w = {w[31:7], rv32_pkg::OP_BRANCH};
        else if (k < 69)
            w = {w[31:7], rv32_pkg::OP_JAL};
        else if (k < 74)
            w = {w[31:7], rv32_pkg::OP_JALR};
        else if (k < 84)
            w = {w[31:7], rv32_pkg::OP_LUI};
        else if (k < 89)
            w = {w[31:7], rv32_pkg::OP_AUIPC};
        else if (k < 92)
            w = {w[31:7], rv32_pkg::OP_SYSTEM};
        else if (k < 95)
            w = {w[31:7], rv32_pkg::OP_OP};
        return w;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        core_result_t got, want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.pc_after = m_tdata[31:0];
            got.reg_written = m_tdata[32];
            got.reg_index = m_tdata[37:33];
            got.reg_value = m_tdata[69:38];
            got.status = m_tdata[72:70];
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.pc_after !== want.pc_after)
                begin
                    $display("%0t: pc_after exp %h got %h", $time, want.pc_after, got.pc_after);
                    errors++;
                end
                if (got.reg_written !== want.reg_written)
                begin
                    $display("%0t: reg_written exp %b got %b", $time,
                             want.reg_written, got.reg_written);
                    errors++;
                end
                if (got.reg_index !== want.reg_index)
                begin
                    $display("%0t: reg_index exp %0d got %0d", $time,
                             want.reg_index, got.reg_index);
                    errors++;
                end
                if (got.reg_value !== want.reg_value)
                begin
                    $display("%0t: reg_value exp %h got %h", $time,
                             want.reg_value, got.reg_value);
                    errors++;
                end
                if (got.status !== want.status)
                begin
                    $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
                    errors++;
                end
            end
        end
    end

    // result side back-pressure
    initial
    begin
        int stall;
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = quiet_rx ? 0 : $urandom_range(0, 6);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            if (($urandom_range(0, 60)) == 0)
                quiet_rx = !quiet_rx;
        end
    end

    initial
    begin
        dir_row_t rows [$];
        core_result_t tr;
        int k, total;

        errors = 0;
        cycles = 0;
        issued = 0;
        quiet_tx = 1'b0;
        quiet_rx = 1'b0;
        rst_n <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        foreach (gpr[i]) gpr[i] = 32'd0;
        foreach (ram_valid[i]) ram_valid[i] = 1'b0;
        foreach (ram[i]) ram[i] = 8'd0;
        cur_pc = 32'd0;
        run_en = 1'b1;

        rows = '{
            '{rv32_pkg::CMD_SETPC, 16'h0000, 8'h00, 16'hFFFF, 32'h0, 1, 32'h0000FFFC,
              rv32_pkg::ST_OK},
            '{rv32_pkg::CMD_WRMEM, 16'hFFFF, 8'hFF, 16'h0000, 32'h0, 1, 32'h0000FFFC,
              rv32_pkg::ST_OK},
            '{rv32_pkg::CMD_CLEAR, 16'hFFFF, 8'hFF, 16'hFFFF, 32'h0, 1, 32'h0,
              rv32_pkg::ST_OK},
            // lui x1
            '{rv32_pkg::CMD_STEP, 16'h0, 8'h0, 16'h0, 32'hFFFFF0B7, 0, 32'h0, rv32_pkg::ST_OK},
            // addi x2,-1
            '{rv32_pkg::CMD_STEP, 16'h0, 8'h0, 16'h0, 32'hFFF00113, 0, 32'h0, rv32_pkg::ST_OK},
            // sub
            '{rv32_pkg::CMD_STEP, 16'h0, 8'h0, 16'h0, 32'h402081B3, 0, 32'h0, rv32_pkg::ST_OK},
            // sra
            '{rv32_pkg::CMD_STEP, 16'h0, 8'h0, 16'h0, 32'h40115233, 0, 32'h0, rv32_pkg::ST_OK},
            // srai 31
            '{rv32_pkg::CMD_STEP, 16'h0, 8'h0, 16'h0, 32'h41F0D293, 0, 32'h0, rv32_pkg::ST_OK},
            // slt
            '{rv32_pkg::CMD_STEP, 16'h0, 8'h0, 16'h0, 32'h0000A333, 0, 32'h0, rv32_pkg::ST_OK},
            // lw misaligned
            '{rv32_pkg::CMD_STEP, 16'h0, 8'h0, 16'h0, 32'h00102383, 0, 32'h0, rv32_pkg::ST_OK},
            // bad load width
            '{rv32_pkg::CMD_STEP, 16'h0, 8'h0, 16'h0, 32'h00003403, 0, 32'h0, rv32_pkg::ST_OK},
            // sw
            '{rv32_pkg::CMD_STEP, 16'h0, 8'h0, 16'h0, 32'h10102023, 0, 32'h0, rv32_pkg::ST_OK},
            // bad store width
            '{rv32_pkg::CMD_STEP, 16'h0, 8'h0, 16'h0, 32'h00003023, 0, 32'h0, rv32_pkg::ST_OK},
            // bad branch
            '{rv32_pkg::CMD_STEP, 16'h0, 8'h0, 16'h0, 32'h00002063, 0, 32'h0, rv32_pkg::ST_OK},
            // bge taken
            '{rv32_pkg::CMD_STEP, 16'h0, 8'h0, 16'h0, 32'h0011D463, 0, 32'h0, rv32_pkg::ST_OK},
            // bgeu not taken
            '{rv32_pkg::CMD_STEP, 16'h0, 8'h0, 16'h0, 32'h0020F463, 0, 32'h0, rv32_pkg::ST_OK},
            // jal -4
            '{rv32_pkg::CMD_STEP, 16'h0, 8'h0, 16'h0, 32'hFFDFF4EF, 0, 32'h0, rv32_pkg::ST_OK},
            // jalr x0
            '{rv32_pkg::CMD_STEP, 16'h0, 8'h0, 16'h0, 32'h00308067, 0, 32'h0, rv32_pkg::ST_OK},
            // auipc
            '{rv32_pkg::CMD_STEP, 16'h0, 8'h0, 16'h0, 32'h80000517, 0, 32'h0, rv32_pkg::ST_OK},
            // ebreak
            '{rv32_pkg::CMD_STEP, 16'h0, 8'h0, 16'h0, 32'h00100073, 0, 32'h0, rv32_pkg::ST_OK},
            // unknown op
            '{rv32_pkg::CMD_STEP, 16'h0, 8'h0, 16'h0, 32'hFFFFFFFF, 0, 32'h0, rv32_pkg::ST_OK}
        };

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_run_enable(1'b1);

        // directed table
        foreach (rows[i])
        begin
            tr = '0;
            tr.pc_after = rows[i].exp_pc;
            tr.status = rows[i].exp_status;
            if (rows[i].cmd == rv32_pkg::CMD_STEP)
            begin
                load_word_at_pc(rows[i].word);
                step_current();
            end
            else
                send_req(rows[i].cmd, rows[i].addr, rows[i].data, rows[i].pc,
                         rows[i].typed, tr);
        end

        // core held: steps change nothing, other commands still act
        write_run_enable(1'b0);
        tr = '0;
        tr.pc_after = cur_pc;
        tr.status = rv32_pkg::ST_HELD;
        send_req(rv32_pkg::CMD_STEP, 16'h0, 8'h0, 16'h0, 1'b1, tr);
        send_cmd(rv32_pkg::CMD_SETPC, 16'h0, 8'h0, 16'h0100);
        send_cmd(rv32_pkg::CMD_STEP, 16'hFFFF, 8'hFF, 16'hFFFF);
        write_run_enable(1'b1);

        // random programs
        total = issued + RANDOM_REQS;
        while (issued < total)
        begin
            k = $urandom_range(0, 99);
            if (k < 4)
                send_cmd(rv32_pkg::CMD_SETPC, 16'($urandom), 8'($urandom), 16'($urandom));
            else if (k < 6)
                send_cmd(rv32_pkg::CMD_CLEAR, 16'($urandom), 8'($urandom), 16'($urandom));
            else if (k < 9)
                send_cmd(rv32_pkg::CMD_WRMEM, 16'($urandom), 8'($urandom), 16'($urandom));
            else if (k == 9)
            begin
                write_run_enable(1'b0);
                repeat ($urandom_range(1, 5))
                    send_cmd(2'($urandom), 16'($urandom), 8'($urandom), 16'($urandom));
                write_run_enable(1'b1);
            end
            else if (k < 25 && ram_valid[16'(cur_pc)] && ram_valid[16'(cur_pc + 1)]
                     && ram_valid[16'(cur_pc + 2)] && ram_valid[16'(cur_pc + 3)])
                step_current();
            else
            begin
                load_word_at_pc(random_insn());
                step_current();
            end
            if ($urandom_range(0, 40) == 0)
                quiet_tx = !quiet_tx;
        end

        wait_idle();
        if (errors == 0)
            $display("PASS rv32i_instruction_core");
        else
            $display("FAIL rv32i_instruction_core");
        $finish;
    end

endmodule
